// ----- rtl/hpq_pkg.sv -----
// Shared definitions for the d-ary heap priority queue.
// Holds codes, the controller state type and the command and status bundles.
// No dependencies.
package hpq_pkg;

	// Input item commands.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Result status codes.
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	// Configuration register map.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int ARITY_W    = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ARITY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODE = 1'd1;
	localparam logic [ARITY_W-1:0]   ARITY_RESET  = 4'd2;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_TEST,
		S_UP_PAR,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_LOAD,
		S_DN_LEVEL,
		S_DN_SCAN,
		S_DN_DRAIN,
		S_DN_DEC,
		S_TOP,
		S_FIN
	} hpq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic up_mul;
		logic up_rd;
		logic up_cmp;
		logic dn_last_rd;
		logic dn_load;
		logic wr_key;
		logic scan_init;
		logic scan_issue;
		logic dn_cmp;
		logic top_rd;
		logic out_load;
	} hpq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ins;
		logic full;
		logic empty;
		logic one_left;
		logic pos_zero;
		logic up_beats;
		logic leaf;
		logic scan_last;
		logic dn_beats;
		logic out_free;
	} hpq_sts_t;

endpackage

// ----- rtl/hpq_req_if.sv -----
// Request channel of the heap priority queue: valid, ready and one item.
// Depends on nothing.
interface hpq_req_if #(
	parameter int KEY_W = 32
);
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink   (input valid, input cmd, input key, output ready);
endinterface

// ----- rtl/hpq_rsp_if.sv -----
// Response channel of the heap priority queue: valid, ready and one result.
// Depends on nothing.
interface hpq_rsp_if #(
	parameter int KEY_W = 32,
	parameter int CNT_W = 9
);
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [KEY_W-1:0] top_key;
	logic             top_valid;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, output status, output top_key, output top_valid,
		output entry_count, input ready);
	modport sink   (input valid, input status, input top_key, input top_valid,
		input entry_count, output ready);
endinterface

// ----- rtl/hpq_ctrl.sv -----
// Controller state machine of the heap priority queue.
// Depends on hpq_pkg and hpq_req_if; drives the datapath through hpq_cmd_t.
module hpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	hpq_req_if.sink          req,
	input  hpq_pkg::hpq_sts_t sts,
	output hpq_pkg::hpq_cmd_t ctl
);
	import hpq_pkg::*;

	hpq_state_t state_q;
	hpq_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ctl.accept = 1'b1;
					if (sts.ins) begin
						state_nxt = sts.full ? S_TOP : S_UP_TEST;
					end else if (sts.empty || sts.one_left) begin
						state_nxt = S_TOP;
					end else begin
						state_nxt = S_DN_LAST;
					end
				end
			end
			// Sift-up: each level passes through the test, parent read and compare states.
			S_UP_TEST: begin
				if (sts.pos_zero) begin
					ctl.wr_key = 1'b1;
					state_nxt  = S_TOP;
				end else begin
					ctl.up_mul = 1'b1;
					state_nxt  = S_UP_PAR;
				end
			end
			S_UP_PAR: begin
				ctl.up_rd = 1'b1;
				state_nxt = S_UP_CMP;
			end
			S_UP_CMP: begin
				ctl.up_cmp = 1'b1;
				state_nxt  = sts.up_beats ? S_UP_TEST : S_TOP;
			end
			// Sift-down: fetch the tail entry, then walk the levels.
			S_DN_LAST: begin
				ctl.dn_last_rd = 1'b1;
				state_nxt      = S_DN_LOAD;
			end
			S_DN_LOAD: begin
				ctl.dn_load = 1'b1;
				state_nxt   = S_DN_LEVEL;
			end
			S_DN_LEVEL: begin
				if (sts.leaf) begin
					ctl.wr_key = 1'b1;
					state_nxt  = S_TOP;
				end else begin
					ctl.scan_init = 1'b1;
					state_nxt     = S_DN_SCAN;
				end
			end
			S_DN_SCAN: begin
				ctl.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_DN_DRAIN;
				end
			end
			S_DN_DRAIN: begin
				state_nxt = S_DN_DEC;
			end
			S_DN_DEC: begin
				ctl.dn_cmp = 1'b1;
				state_nxt  = sts.dn_beats ? S_DN_LEVEL : S_TOP;
			end
			// Fetch the root and hand the result to the output register.
			S_TOP: begin
				ctl.top_rd = 1'b1;
				state_nxt  = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/hpq_datapath.sv -----
// Datapath of the heap priority queue: heap memory, configuration, index arithmetic,
// key comparison and the output register. Depends on hpq_pkg and hpq_rsp_if.
module hpq_datapath #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32,
	parameter int MAX_ARITY = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hpq_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [hpq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             req_cmd,
	input  logic [KEY_WIDTH-1:0]             req_key,
	input  hpq_pkg::hpq_cmd_t                ctl,
	output hpq_pkg::hpq_sts_t                sts,
	hpq_rsp_if.source                        rsp
);
	import hpq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DW    = $clog2(MAX_ARITY + 1);
	// Reciprocal scale: exact floor division of any index by any arity.
	localparam int S     = IDX_W + DW;
	localparam int RW    = S;
	localparam int PW    = IDX_W + RW;
	localparam int FW    = IDX_W + DW + 1;
	localparam int CW1   = CNT_W + 1;
	localparam int DW1   = DW + 1;

	// Heap memory, one write and one read port, registered read data.
	logic [KEY_WIDTH-1:0] mem [0:CAPACITY-1];
	logic [KEY_WIDTH-1:0] rd_q;
	logic                 mem_we;
	logic [IDX_W-1:0]     waddr;
	logic [KEY_WIDTH-1:0] wdata;
	logic                 rd_en;
	logic [IDX_W-1:0]     raddr;

	// Configuration and count.
	logic [ARITY_W-1:0]   ar_q;
	logic                 mx_q;
	logic [DW-1:0]        d_eff;
	logic [CNT_W-1:0]     cnt_q;

	// Working registers.
	logic [KEY_WIDTH-1:0] key_q;
	logic [IDX_W-1:0]     pos_q;
	logic [IDX_W-1:0]     par_q;
	logic [PW-1:0]        prod_s1;
	logic [IDX_W-1:0]     par_w;
	logic [FW-1:0]        first_w;
	logic [IDX_W-1:0]     cidx_q;
	logic [DW-1:0]        k_q;
	logic                 chk_s1;
	logic [IDX_W-1:0]     cidx_s1;
	logic                 kfirst_s1;
	logic [KEY_WIDTH-1:0] best_key_q;
	logic [IDX_W-1:0]     best_idx_q;

	// Output register.
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [KEY_WIDTH-1:0] out_top_q;
	logic                 out_tv_q;
	logic [CNT_W-1:0]     out_cnt_q;

	logic [RW-1:0]        recip_tab [0:MAX_ARITY];

	function automatic logic beats(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic mx);
		return mx ? (a > b) : (a < b);
	endfunction

	// Reciprocal table: ceil(2^S / d) for each arity.
	for (genvar g = 0; g <= MAX_ARITY; g++) begin : g_rc
		if (g < 2) begin : g_unused
			assign recip_tab[g] = '0;
		end else begin : g_val
			localparam logic [RW-1:0] RC =
				RW'(((64'd1 << S) + 64'(g) - 64'd1) / 64'(g));
			assign recip_tab[g] = RC;
		end
	end

	// Effective arity, clamped to the supported range.
	always_comb begin
		if (ar_q < ARITY_W'(2)) begin
			d_eff = DW'(2);
		end else if (32'(ar_q) > MAX_ARITY) begin
			d_eff = DW'(MAX_ARITY);
		end else begin
			d_eff = DW'(ar_q);
		end
	end

	// Index arithmetic: parent from the registered product, first child directly.
	assign par_w   = prod_s1[S +: IDX_W];
	assign first_w = FW'(d_eff) * FW'(pos_q) + FW'(1);

	// Status to the controller.
	always_comb begin
		sts.ins       = (req_cmd == CMD_INSERT);
		sts.full      = (cnt_q == CNT_W'(CAPACITY));
		sts.empty     = (cnt_q == '0);
		sts.one_left  = (cnt_q == CNT_W'(1));
		sts.pos_zero  = (pos_q == '0);
		sts.up_beats  = beats(key_q, rd_q, mx_q);
		sts.leaf      = (first_w >= FW'(cnt_q));
		sts.scan_last = ((CW1'(cidx_q) + CW1'(1)) >= CW1'(cnt_q))
			|| ((DW1'(k_q) + DW1'(1)) >= DW1'(d_eff));
		sts.dn_beats  = beats(best_key_q, key_q, mx_q);
		sts.out_free  = !out_valid_q || rsp.ready;
	end

	// Memory port selection.
	always_comb begin
		mem_we = ctl.wr_key || ctl.up_cmp || ctl.dn_cmp;
		waddr  = pos_q;
		if (ctl.up_cmp && sts.up_beats) begin
			wdata = rd_q;
		end else if (ctl.dn_cmp && sts.dn_beats) begin
			wdata = best_key_q;
		end else begin
			wdata = key_q;
		end
		rd_en = ctl.up_rd || ctl.dn_last_rd || ctl.scan_issue || ctl.top_rd;
		if (ctl.up_rd) begin
			raddr = par_w;
		end else if (ctl.dn_last_rd) begin
			raddr = cnt_q[IDX_W-1:0];
		end else if (ctl.scan_issue) begin
			raddr = cidx_q;
		end else begin
			raddr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	// Configuration registers and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ar_q  <= ARITY_RESET;
			mx_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ARITY:    ar_q <= cfg_wdata[ARITY_W-1:0];
					CFG_MAX_MODE: mx_q <= cfg_wdata[0];
					default:      ;
				endcase
			end
			if (ctl.accept) begin
				if (sts.ins && !sts.full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (!sts.ins && !sts.empty) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Moving key, hole position and parent index.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			key_q    <= req_key;
			pos_q    <= cnt_q[IDX_W-1:0];
			status_q <= sts.ins ? (sts.full ? STAT_FULL : STAT_OK)
				: (sts.empty ? STAT_EMPTY : STAT_OK);
		end else if (ctl.dn_load) begin
			key_q <= rd_q;
			pos_q <= '0;
		end else if (ctl.up_cmp && sts.up_beats) begin
			pos_q <= par_q;
		end else if (ctl.dn_cmp && sts.dn_beats) begin
			pos_q <= best_idx_q;
		end
		if (ctl.up_mul) begin
			prod_s1 <= PW'(pos_q - IDX_W'(1)) * PW'(recip_tab[d_eff]);
		end
		if (ctl.up_rd) begin
			par_q <= par_w;
		end
	end

	// Child scan: one read issued per cycle, compared in the cycle after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= ctl.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_init) begin
			cidx_q <= first_w[IDX_W-1:0];
			k_q    <= '0;
		end else if (ctl.scan_issue) begin
			cidx_q <= cidx_q + IDX_W'(1);
			k_q    <= k_q + DW'(1);
		end
		cidx_s1   <= cidx_q;
		kfirst_s1 <= (k_q == '0);
		if (chk_s1 && (kfirst_s1 || beats(rd_q, best_key_q, mx_q))) begin
			best_key_q <= rd_q;
			best_idx_q <= cidx_s1;
		end
	end

	// Output register: holds one result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= status_q;
			out_top_q    <= (cnt_q != '0) ? rd_q : '0;
			out_tv_q     <= (cnt_q != '0);
			out_cnt_q    <= cnt_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.top_key     = out_top_q;
	assign rsp.top_valid   = out_tv_q;
	assign rsp.entry_count = out_cnt_q;

endmodule

// ----- rtl/dary_heap_priority_queue.sv -----
// Top level of the d-ary heap priority queue.
// Depends on hpq_pkg, hpq_req_if, hpq_rsp_if, hpq_ctrl and hpq_datapath.
//
// req carries one beat per item (cmd: insert or remove top, and key); rsp returns
// one beat per item (status, top_key, top_valid, entry_count after the operation).
// cfg_we/cfg_idx/cfg_wdata write arity (index 0) and max_mode (index 1); write
// them only while no item is in flight.
// One item is worked on at a time. An insert rises one level at a time from the tail;
// a remove moves the tail entry to the root and sinks it level by level, scanning
// the children of each level one per cycle (at most the arity) through the single
// memory read port. A dropped insert or a remove that leaves the heap empty goes
// straight to reading the root.
// arst_n clears the count (empty heap), sets arity 2 and min ordering. The heap
// memory is not cleared; entries beyond the count never reach a result.
// A finished result waits in the output register while a new request is taken;
// a further result waits until the receiver takes the first.
module dary_heap_priority_queue #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32,
	parameter int MAX_ARITY = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hpq_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hpq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	hpq_req_if.sink                        req,
	hpq_rsp_if.source                      rsp
);
	import hpq_pkg::*;

	hpq_cmd_t ctl;
	hpq_sts_t sts;

	// Sequencer.
	hpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Memory, arithmetic and output register.
	hpq_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH),
		.MAX_ARITY (MAX_ARITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_cmd   (req.cmd),
		.req_key   (req.key),
		.ctl       (ctl),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/hpq_chk.sv -----
// Port checker for the heap priority queue and its bind to the top level.
// Depends on hpq_pkg and dary_heap_priority_queue.
module hpq_chk #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = 9
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [1:0]           rsp_status,
	input logic [KEY_WIDTH-1:0] rsp_top_key,
	input logic                 rsp_top_valid,
	input logic [CNT_W-1:0]     rsp_entry_count
);
	import hpq_pkg::*;

	// The count in a result never exceeds the capacity.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_entry_count) <= CAPACITY))
		else $error("entry_count beyond capacity");

	// top_valid follows the count, and an empty heap shows a zero key.
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_top_valid == (rsp_entry_count != '0))
			&& (rsp_top_valid || (rsp_top_key == '0))))
		else $error("top_valid or top_key inconsistent with entry_count");

	// A dropped insert is reported only with a full heap.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status == STAT_FULL)) |-> (32'(rsp_entry_count) == CAPACITY))
		else $error("full status with a heap that is not full");

	// A remove on an empty heap leaves it empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status == STAT_EMPTY)) |-> (rsp_entry_count == '0))
		else $error("empty status with entries held");

	// A stalled result beat holds its status, top_key and entry_count.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
			&& $stable(rsp_top_key) && $stable(rsp_entry_count)))
		else $error("stalled result beat changed");

endmodule

bind dary_heap_priority_queue hpq_chk #(
	.CAPACITY  (CAPACITY),
	.KEY_WIDTH (KEY_WIDTH),
	.CNT_W     ($clog2(CAPACITY + 1))
) u_hpq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_top_key     (rsp.top_key),
	.rsp_top_valid   (rsp.top_valid),
	.rsp_entry_count (rsp.entry_count)
);

// ----- bench/hpq_order_check.sv -----
`timescale 1ns / 1ps
// Checker for the d-ary heap priority queue: keeps its own heap, predicts each result beat.
// Depends on hpq_pkg, hpq_req_if and hpq_rsp_if.
module hpq_order_check #(
	parameter int CAPACITY  = 256,
	parameter int KEY_W     = 32,
	parameter int CNT_W     = 9,
	parameter int MAX_ARITY = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hpq_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [hpq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	hpq_req_if                             req,
	hpq_rsp_if                             rsp,
	output int                             fail_count,
	output int                             pending
);
	import hpq_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    top_key;
		logic                top_valid;
		logic [CNT_W-1:0]    entry_count;
	} hpq_result_t;

	// Shadow copy of the heap and its settings.
	logic [KEY_W-1:0]   heap_keys [CAPACITY];
	int                 heap_fill;
	logic [ARITY_W-1:0] heap_arity;
	logic               heap_max_mode;
	hpq_result_t        due_results [$];

	function automatic logic key_wins(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		return heap_max_mode ? (a > b) : (a < b);
	endfunction

	function automatic void swap_keys(input int a, input int b);
		logic [KEY_W-1:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// Applies one request beat to the shadow heap and returns the result it should give.
	function automatic hpq_result_t heap_apply(input logic cmd_v, input logic [KEY_W-1:0] key_v);
		hpq_result_t r;
		int d;
		int pos;
		int parent;
		int first;
		int best;
		d = (heap_arity < 2) ? 2 : ((heap_arity > MAX_ARITY) ? MAX_ARITY : int'(heap_arity));
		r.status = STAT_OK;
		if (cmd_v == CMD_INSERT) begin
			if (heap_fill >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				// Place at the tail and rise while strictly better than the parent.
				heap_keys[heap_fill] = key_v;
				pos = heap_fill;
				heap_fill++;
				while (pos > 0) begin
					parent = (pos - 1) / d;
					if (!key_wins(heap_keys[pos], heap_keys[parent]))
						break;
					swap_keys(pos, parent);
					pos = parent;
				end
			end
		end else if (heap_fill == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			// Last entry moves to the root, then sinks towards the first best child.
			heap_fill--;
			if (heap_fill > 0) begin
				heap_keys[0] = heap_keys[heap_fill];
				pos = 0;
				forever begin
					first = d * pos + 1;
					if (first >= heap_fill)
						break;
					best = first;
					for (int k = 1; k < d && first + k < heap_fill; k++) begin
						if (key_wins(heap_keys[first + k], heap_keys[best]))
							best = first + k;
					end
					if (!key_wins(heap_keys[best], heap_keys[pos]))
						break;
					swap_keys(pos, best);
					pos = best;
				end
			end
		end
		r.top_valid   = (heap_fill > 0);
		r.top_key     = (heap_fill > 0) ? heap_keys[0] : '0;
		r.entry_count = CNT_W'(heap_fill);
		return r;
	endfunction

	function automatic void note_mismatch(input string field, input logic [KEY_W-1:0] want_v,
			input logic [KEY_W-1:0] got_v);
		fail_count++;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
	endfunction

	// Result beats are checked before the request beat of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		hpq_result_t want;
		if (!arst_n) begin
			heap_fill     = 0;
			heap_arity    = ARITY_RESET;
			heap_max_mode = 1'b0;
			due_results.delete();
			fail_count    = 0;
			pending       = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected, got status %0d top_key %0h",
						$time, rsp.status, rsp.top_key);
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status)
						note_mismatch("status", want.status, rsp.status);
					if (rsp.top_key !== want.top_key)
						note_mismatch("top_key", want.top_key, rsp.top_key);
					if (rsp.top_valid !== want.top_valid)
						note_mismatch("top_valid", want.top_valid, rsp.top_valid);
					if (rsp.entry_count !== want.entry_count)
						note_mismatch("entry_count", want.entry_count, rsp.entry_count);
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_ARITY)
					heap_arity = cfg_wdata[ARITY_W-1:0];
				else if (cfg_idx == CFG_MAX_MODE)
					heap_max_mode = cfg_wdata[0];
			end
			if (req.valid && req.ready)
				due_results = {due_results, heap_apply(req.cmd, req.key)};
			pending = due_results.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the heap priority queue bench: clock, reset, stimulus and verdict.
// Depends on hpq_pkg, the channel interfaces, the block and hpq_order_check.
module tb_top;
	import hpq_pkg::*;

	localparam int CAPACITY  = 256;
	localparam int KEY_W     = 32;
	localparam int CNT_W     = 9;
	localparam int MAX_ARITY = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending;
	int                    idle_pct;
	int                    stall_pct;
	int                    level;
	int                    arity_plan [8] = '{2, 8, 0, 15, 3, 5, 1, 9};
	int                    idle_plan  [4] = '{0, 73, 0, 20};
	int                    stall_plan [4] = '{0, 0, 73, 20};

	hpq_req_if #(.KEY_W(KEY_W))                req_ch ();
	hpq_rsp_if #(.KEY_W(KEY_W), .CNT_W(CNT_W)) rsp_ch ();

	dary_heap_priority_queue #(
		.CAPACITY (CAPACITY),
		.KEY_WIDTH(KEY_W),
		.MAX_ARITY(MAX_ARITY)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	hpq_order_check #(
		.CAPACITY (CAPACITY),
		.KEY_W    (KEY_W),
		.CNT_W    (CNT_W),
		.MAX_ARITY(MAX_ARITY)
	) order_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Upper bound on the run, far beyond the slowest correct one.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// The receiver stalls at random, at the rate of the current phase.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Sends one request beat, after a random gap, and returns at the falling edge after it.
	task automatic send_item(input logic cmd_v, input logic [KEY_W-1:0] key_v);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd   = cmd_v;
		req_ch.key   = key_v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (cmd_v == CMD_INSERT && level < CAPACITY)
			level++;
		else if (cmd_v == CMD_REMOVE && level > 0)
			level--;
	endtask

	// Holds off the sender until every expected result beat has been taken.
	task automatic drain_results();
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Keys lean on the extremes and on a narrow range so that ties are common.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return KEY_W'($urandom_range(7));
			default: return KEY_W'($urandom());
		endcase
	endfunction

	task automatic run_mix(input int n, input int ins_pct);
		repeat (n) begin
			if ($urandom_range(99) < ins_pct)
				send_item(CMD_INSERT, pick_key());
			else
				send_item(CMD_REMOVE, KEY_W'($urandom()));
		end
	endtask

	task automatic set_pace(input int profile);
		idle_pct  = idle_plan[profile];
		stall_pct = stall_plan[profile];
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_ARITY;
		cfg_wdata    = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_INSERT;
		req_ch.key   = '0;
		level        = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at reset settings: empty remove, extremes, ties, then a full drain.
		send_item(CMD_REMOVE, '1);
		send_item(CMD_INSERT, '1);
		send_item(CMD_INSERT, '0);
		send_item(CMD_INSERT, '0);
		send_item(CMD_INSERT, KEY_W'(7));
		send_item(CMD_INSERT, KEY_W'(7));
		send_item(CMD_INSERT, KEY_W'(7));
		send_item(CMD_INSERT, KEY_W'(32'h8000_0000));
		send_item(CMD_INSERT, KEY_W'(32'h7FFF_FFFF));
		send_item(CMD_INSERT, KEY_W'(1));
		while (level > 0)
			send_item(CMD_REMOVE, '0);
		send_item(CMD_REMOVE, '0);

		// Max ordering with extremes and ties, left partly filled for the next phase.
		write_reg(CFG_MAX_MODE, CFG_DATA_W'(1));
		send_item(CMD_INSERT, '0);
		send_item(CMD_INSERT, '1);
		send_item(CMD_INSERT, '1);
		send_item(CMD_REMOVE, '0);

		// Random phases; the heap is kept across each change of ordering and arity.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_ARITY, CFG_DATA_W'(arity_plan[ph]));
			write_reg(CFG_MAX_MODE, {CFG_DATA_W'($urandom_range(7)) << 1} | CFG_DATA_W'(ph % 2));
			set_pace(ph % 4);
			run_mix(10, (ph < 4) ? 70 : 40);
		end

		// Fill to capacity, flipping the ordering and raising the arity half way, then overfill and take a share out.
		write_reg(CFG_ARITY, CFG_DATA_W'(2));
		write_reg(CFG_MAX_MODE, CFG_DATA_W'(0));
		set_pace(3);
		while (level < CAPACITY / 2)
			send_item(CMD_INSERT, pick_key());
		write_reg(CFG_MAX_MODE, CFG_DATA_W'(1));
		write_reg(CFG_ARITY, CFG_DATA_W'(3));
		while (level < CAPACITY)
			send_item(CMD_INSERT, pick_key());
		repeat (3) send_item(CMD_INSERT, pick_key());
		set_pace(0);
		repeat (40) send_item(CMD_REMOVE, KEY_W'($urandom()));

		// Closing mix at the widest arity.
		write_reg(CFG_ARITY, CFG_DATA_W'(MAX_ARITY));
		set_pace(2);
		run_mix(30, 60);

		drain_results();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
